[hdl/gmmp_pkg.sv]
`default_nettype none

package gmmp_pkg;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_IMAGE_VER  = 3'd1;
    localparam logic [2:0] ERR_VERSION    = 3'd2;
    localparam logic [2:0] ERR_BACKWARD   = 3'd3;
    localparam logic [2:0] ERR_RSVD_FLAGS = 3'd4;
    localparam logic [2:0] ERR_ZERO_DENOM = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd6;
    localparam logic [2:0] ERR_TRAILING   = 3'd7;

    // Rational kinds
    localparam logic [2:0] KIND_BASE_HEADROOM = 3'd0;
    localparam logic [2:0] KIND_ALT_HEADROOM  = 3'd1;
    localparam logic [2:0] KIND_GAIN_MIN      = 3'd2;
    localparam logic [2:0] KIND_ALT_OFFSET    = 3'd6;

    // Header byte positions
    localparam logic [3:0] POS_IMAGE_VER = 4'd0;
    localparam logic [3:0] POS_VER_LAST  = 4'd4;
    localparam logic [3:0] POS_FLAGS     = 4'd5;
    localparam logic [3:0] POS_BODY      = 4'd6;

    // Flag byte masks
    localparam logic [7:0] FLAG_BACKWARD = 8'h04;
    localparam logic [7:0] FLAG_ALLOWED  = 8'hC8;

    // Byte index within a word or rational at which it completes
    localparam logic [2:0] IDX_WORD_END = 3'd3;
    localparam logic [2:0] IDX_PAIR_END = 3'd7;

    localparam logic [1:0] CHAN_LAST = 2'd2;

endpackage

`default_nettype wire

[hdl/gain_map_metadata_parser_core.sv]
`default_nettype none

// Gain-map metadata parser.
// Slave side: one payload byte per beat on s_axis_tdata, s_axis_tlast on the
// payload's final byte. Header (image version, two version words, flags) is
// checked, then every headroom and per-channel rational is sent on the master
// side as one beat: tdata = {denominator, numerator}, tuser carries the kind,
// channel, flag bits and error code, tlast marks the last beat of a payload.
// An error gives one beat with zero values, the code in tuser and tlast set;
// the rest of the payload up to its final byte is then dropped silently.
// The result of an accepted byte is in the output register in the cycle after
// it is taken. Throughput: one byte per cycle while s_axis_tready is high,
// set by the combinational decode between the byte handshake and the result
// register; the parser state is updated in the same cycle a byte is taken.
// s_axis_tready stays high while the output register is empty or being
// drained, so a stalled receiver holds one result and then back-pressures.
// Reset (synchronous, active low) empties the output register and returns
// the parser to the start of a payload.
module gain_map_metadata_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] numerator, [63:32] denominator
    output logic [10:0]      m_axis_tuser,   // [2:0] field_kind, [4:3] channel_index,
                                             // [5] multichannel, [6] base_color_space,
                                             // [7] shared_denominator, [10:8] error_code
    output logic             m_axis_tlast    // last_result
);
    import gmmp_pkg::*;

    // parser state
    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_flags, n_flags;          // {multi, base cs, shared}
    logic [31:0] r_cden, n_cden;
    logic [31:0] r_word, n_word;
    logic [31:0] r_held, n_held;
    logic [2:0]  r_field, n_field;
    logic [1:0]  r_chan, n_chan;
    logic        r_discard, n_discard;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [10:0] r_out_user;
    logic        r_out_last;

    logic        accept;
    logic        fin;
    logic [7:0]  b;

    // decode results
    logic        res_valid;
    logic        res_last;
    logic [2:0]  res_kind;
    logic [1:0]  res_chan;
    logic [31:0] res_num;
    logic [31:0] res_den;
    logic [2:0]  res_err;
    logic [2:0]  res_flags;

    logic        do_fail;
    logic [2:0]  fail_code;
    logic        complete;
    logic        restart;
    logic [31:0] w;
    logic [2:0]  k;
    logic        shared;
    logic        multi;
    logic        is_last;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign fin           = s_axis_tlast;
    assign b             = s_axis_tdata;
    assign w             = {r_word[23:0], b};
    assign k             = 3'(r_pos - POS_BODY);
    assign shared        = r_flags[0];
    assign multi         = r_flags[2];

    always_comb begin
        n_pos     = r_pos;
        n_flags   = r_flags;
        n_cden    = r_cden;
        n_word    = r_word;
        n_held    = r_held;
        n_field   = r_field;
        n_chan    = r_chan;
        n_discard = r_discard;

        do_fail   = 1'b0;
        fail_code = ERR_NONE;
        complete  = 1'b0;
        restart   = 1'b0;
        is_last   = 1'b0;
        res_valid = 1'b0;
        res_last  = 1'b0;
        res_kind  = KIND_BASE_HEADROOM;
        res_chan  = '0;
        res_num   = '0;
        res_den   = '0;
        res_err   = ERR_NONE;
        res_flags = (r_pos == POS_FLAGS) ? {b[7], b[6], b[3]} : r_flags;

        if (r_discard) begin
            restart = fin;
        end else if (r_pos < POS_FLAGS) begin
            if ((r_pos == POS_IMAGE_VER && b != 8'd0) || fin) begin
                do_fail   = 1'b1;
                fail_code = ERR_IMAGE_VER;
            end else if (r_pos == POS_VER_LAST && (r_word[7:0] | b) != 8'd0) begin
                do_fail   = 1'b1;
                fail_code = ERR_VERSION;
            end else begin
                n_word = (r_pos == POS_VER_LAST) ? '0 : (r_word | {24'd0, b});
                n_pos  = r_pos + 4'd1;
            end
        end else if (r_pos == POS_FLAGS) begin
            n_flags = {b[7], b[6], b[3]};
            if ((b & FLAG_BACKWARD) != 8'd0) begin
                do_fail   = 1'b1;
                fail_code = ERR_BACKWARD;
            end else if ((b & ~FLAG_ALLOWED) != 8'd0) begin
                do_fail   = 1'b1;
                fail_code = ERR_RSVD_FLAGS;
            end else if (fin) begin
                do_fail   = 1'b1;
                fail_code = ERR_TRUNCATED;
            end else begin
                n_word = '0;
                n_pos  = POS_BODY;
            end
        end else if (shared) begin
            if (k < IDX_WORD_END) begin
                n_word = w;
                if (fin) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end else begin
                n_word = '0;
                n_pos  = POS_BODY;
                if (r_cden == '0) begin
                    if (w == '0) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_ZERO_DENOM;
                    end else if (fin) begin
                        do_fail   = 1'b1;
                        fail_code = ERR_TRUNCATED;
                    end else begin
                        n_cden = w;
                    end
                end else begin
                    complete = 1'b1;
                    res_num  = w;
                    res_den  = r_cden;
                end
            end
        end else begin
            if (k < IDX_PAIR_END) begin
                n_word = w;
                if (k == IDX_WORD_END) begin
                    n_held = w;
                    n_word = '0;
                end
                if (fin) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRUNCATED;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end else begin
                n_word = '0;
                n_pos  = POS_BODY;
                if (w == '0) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_ZERO_DENOM;
                end else begin
                    complete = 1'b1;
                    res_num  = r_held;
                    res_den  = w;
                end
            end
        end

        if (complete) begin
            res_kind = r_field;
            res_chan = (r_field >= KIND_GAIN_MIN) ? r_chan : 2'd0;
            is_last  = (r_field >= KIND_ALT_OFFSET) && (!multi || r_chan >= CHAN_LAST);
            if (is_last) begin
                if (!fin) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_TRAILING;
                end else begin
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                    restart   = 1'b1;
                end
            end else if (fin) begin
                do_fail   = 1'b1;
                fail_code = ERR_TRUNCATED;
            end else begin
                res_valid = 1'b1;
                if (r_field < KIND_ALT_OFFSET) begin
                    n_field = r_field + 3'd1;
                end else begin
                    n_field = KIND_GAIN_MIN;
                    n_chan  = r_chan + 2'd1;
                end
            end
        end

        if (do_fail) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_kind  = KIND_BASE_HEADROOM;
            res_chan  = '0;
            res_num   = '0;
            res_den   = '0;
            res_err   = fail_code;
            restart   = 1'b1;
        end

        if (restart) begin
            n_pos     = POS_IMAGE_VER;
            n_flags   = '0;
            n_cden    = '0;
            n_word    = '0;
            n_held    = '0;
            n_field   = KIND_BASE_HEADROOM;
            n_chan    = '0;
            n_discard = do_fail && !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_IMAGE_VER;
            r_flags   <= '0;
            r_cden    <= '0;
            r_word    <= '0;
            r_held    <= '0;
            r_field   <= KIND_BASE_HEADROOM;
            r_chan    <= '0;
            r_discard <= 1'b0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_flags   <= n_flags;
            r_cden    <= n_cden;
            r_word    <= n_word;
            r_held    <= n_held;
            r_field   <= n_field;
            r_chan    <= n_chan;
            r_discard <= n_discard;
        end
    end

    // result register: loads whenever a byte is taken, since then it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_data <= {res_den, res_num};
            r_out_user <= {res_err, res_flags[0], res_flags[1], res_flags[2],
                           res_chan, res_kind};
            r_out_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
